// File: rtl/core/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types, constants and the step wrap table of the step sequencer
// with glide.
// ----------------------------------------------------------------------------
package sws_pkg;

    // Field and register widths.
    localparam int NOTE_W      = 7;
    localparam int STEP_W      = 4;
    localparam int LEN_W       = 5;
    localparam int MASK_W      = 16;
    localparam int COEF_W      = 16;
    localparam int GATE_W      = 16;
    localparam int CFG_DATA_W  = 28;
    localparam int CFG_ADDR_W  = 3;
    localparam int NOTE_REGS   = 4;
    localparam int NOTES_PER_REG = 4;

    // Sequencer constants.
    localparam int STEP_COUNT    = 16;
    localparam int GATE_TICKS    = 1024;
    localparam int FRAC_BITS_DEF = 16;

    // Register reset values.
    localparam logic [CFG_DATA_W-1:0] NOTES_RST_0 = 28'd137371452;
    localparam logic [CFG_DATA_W-1:0] NOTES_RST_1 = 28'd152167107;
    localparam logic [CFG_DATA_W-1:0] NOTES_RST_2 = 28'd166946378;
    localparam logic [CFG_DATA_W-1:0] NOTES_RST_3 = 28'd181742033;
    localparam logic [MASK_W-1:0]     REST_RST    = '0;
    localparam logic [LEN_W-1:0]      LEN_RST     = 5'd8;
    localparam logic [COEF_W-1:0]     COEF_RST    = '0;
    localparam logic [NOTE_W-1:0]     TARGET_RST  = 7'd60;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_NOTES_0  = 3'd0,
        CFG_NOTES_1  = 3'd1,
        CFG_NOTES_2  = 3'd2,
        CFG_NOTES_3  = 3'd3,
        CFG_REST     = 3'd4,
        CFG_LENGTH   = 3'd5,
        CFG_COEF     = 3'd6
    } cfg_addr_t;

    // Four notes packed into one register, step 0 of the group lowest.
    typedef logic [NOTES_PER_REG-1:0][NOTE_W-1:0] note_quad_t;

    // Sequencer settings handed to the step control.
    typedef struct packed {
        note_quad_t [NOTE_REGS-1:0] notes;
        logic [MASK_W-1:0]          rest_mask;
        logic [LEN_W-1:0]           seq_length;
    } sws_cfg_t;

    // Per-tick result of the step control.
    typedef struct packed {
        logic [NOTE_W-1:0] target_note;
        logic              gate;
    } sws_step_out_t;

    // Wrap table: entry {step, length - 1} holds (step + 1) mod length.
    localparam int WRAP_ENTRIES = (1 << STEP_W) * (1 << STEP_W);
    typedef logic [WRAP_ENTRIES-1:0][STEP_W-1:0] wrap_table_t;

    function automatic wrap_table_t build_wrap_table();
        wrap_table_t tbl;
        int          n;
        int          k;
        for (int s = 0; s < (1 << STEP_W); s++) begin
            for (int l = 1; l <= (1 << STEP_W); l++) begin
                n = s + 1;
                for (k = 0; k <= (1 << STEP_W); k++) begin
                    if (n >= l) begin
                        n = n - l;
                    end
                end
                tbl[s * (1 << STEP_W) + l - 1] = STEP_W'(n);
            end
        end
        return tbl;
    endfunction

    localparam wrap_table_t WRAP_TABLE = build_wrap_table();

endpackage

// File: rtl/core/sws_step_ctrl.sv
// ----------------------------------------------------------------------------
// sws_step_ctrl
// Edge detection on the clock and reset levels, step counter, rest handling,
// target note selection and the gate counter.
// ----------------------------------------------------------------------------
module sws_step_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic                  clock_level,
    input  logic                  reset_level,
    input  sws_pkg::sws_cfg_t     cfg,
    output sws_pkg::sws_step_out_t step_out
);
    import sws_pkg::*;

    logic                   last_clk_reg, last_clk_next;
    logic                   last_rst_reg, last_rst_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [GATE_W-1:0]      gate_cnt_reg, gate_cnt_next;
    logic [NOTE_W-1:0]      target_reg, target_next;

    logic                   rst_edge;
    logic                   clk_edge;
    logic [STEP_W-1:0]      step_a;
    logic [GATE_W-1:0]      gate_a;
    logic [GATE_W-1:0]      gate_b;
    logic [LEN_W-1:0]       len_eff;
    logic [STEP_W-1:0]      len_idx;
    logic [STEP_W-1:0]      step_wrap;
    logic                   gate_on;

    // Rising edges of the two levels against the previous tick.
    assign rst_edge = reset_level & ~last_rst_reg;
    assign clk_edge = clock_level & ~last_clk_reg;

    // Active length, clamped to one through the step count.
    always_comb begin
        len_eff = cfg.seq_length;
        if (len_eff == '0) begin
            len_eff = LEN_W'(1);
        end else if (len_eff > LEN_W'(STEP_COUNT)) begin
            len_eff = LEN_W'(STEP_COUNT);
        end
    end

    assign len_idx   = STEP_W'(len_eff - LEN_W'(1));
    assign step_a    = rst_edge ? '0 : step_reg;
    assign gate_a    = rst_edge ? '0 : gate_cnt_reg;
    assign step_wrap = WRAP_TABLE[{step_a, len_idx}];

    // Clock edge: advance, and retrigger unless the new step is a rest.
    always_comb begin
        step_next   = step_a;
        target_next = target_reg;
        gate_b      = gate_a;
        if (clk_edge) begin
            step_next = step_wrap;
            if (!cfg.rest_mask[step_wrap]) begin
                target_next = cfg.notes[step_wrap[3:2]][step_wrap[1:0]];
                gate_b      = GATE_W'(GATE_TICKS);
            end
        end
    end

    // The gate shows the counter before this tick's decrement.
    assign gate_on       = (gate_b != '0);
    assign gate_cnt_next = gate_b - GATE_W'(gate_on);
    assign last_clk_next = clock_level;
    assign last_rst_next = reset_level;

    assign step_out.target_note = target_next;
    assign step_out.gate        = gate_on;

    // State registers advance once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_clk_reg <= 1'b0;
            last_rst_reg <= 1'b0;
            step_reg     <= '0;
            gate_cnt_reg <= '0;
            target_reg   <= TARGET_RST;
        end else if (accept) begin
            last_clk_reg <= last_clk_next;
            last_rst_reg <= last_rst_next;
            step_reg     <= step_next;
            gate_cnt_reg <= gate_cnt_next;
            target_reg   <= target_next;
        end
    end

endmodule

// File: rtl/core/sws_glide.sv
// ----------------------------------------------------------------------------
// sws_glide
// One-pole glide of the pitch toward the target note, one update per tick.
// ----------------------------------------------------------------------------
module sws_glide #(
    parameter int FRAC_BITS = sws_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  accept,
    input  logic [sws_pkg::COEF_W-1:0]            coef,
    input  logic [sws_pkg::NOTE_W-1:0]            target_note,
    output logic [sws_pkg::NOTE_W+FRAC_BITS-1:0]  pitch
);
    import sws_pkg::*;

    localparam int PITCH_W = NOTE_W + FRAC_BITS;
    localparam int ACC_W   = PITCH_W + COEF_W + 2;
    localparam logic [PITCH_W-1:0] PITCH_RST = {TARGET_RST, {FRAC_BITS{1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-COEF_W){1'b0}}, 1'b1, {(COEF_W-1){1'b0}}};

    logic [PITCH_W-1:0]        pitch_reg, pitch_next;
    logic [PITCH_W-1:0]        target_fx;
    logic signed [PITCH_W:0]   diff;
    logic signed [ACC_W-1:0]   diff_ext;
    logic signed [ACC_W-1:0]   coef_ext;
    logic signed [ACC_W-1:0]   target_ext;
    logic signed [ACC_W-1:0]   prod;
    logic signed [ACC_W-1:0]   acc;

    // P' = T + c * (P - T) / 2^16, rounded half up. A zero coefficient
    // lands exactly on the target.
    assign target_fx  = {target_note, {FRAC_BITS{1'b0}}};
    assign diff       = $signed({1'b0, pitch_reg}) - $signed({1'b0, target_fx});
    assign diff_ext   = {{(ACC_W-PITCH_W-1){diff[PITCH_W]}}, diff};
    assign coef_ext   = {{(ACC_W-COEF_W){1'b0}}, coef};
    assign target_ext = {2'b00, target_fx, {COEF_W{1'b0}}};
    assign prod       = diff_ext * coef_ext;
    assign acc        = target_ext + prod + ROUND_HALF;
    assign pitch_next = acc[PITCH_W+COEF_W-1:COEF_W];

    assign pitch = pitch_reg;

    // Pitch register, which is also the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg <= PITCH_RST;
        end else if (accept) begin
            pitch_reg <= pitch_next;
        end
    end

endmodule

// File: rtl/core/step_sequencer_with_glide.sv
// ----------------------------------------------------------------------------
// step_sequencer_with_glide
// CV/gate step sequencer with one-pole pitch glide, one tick per word.
// ----------------------------------------------------------------------------
// Each input word is one sample tick with the clock and reset levels. A
// rising reset level returns the sequence to step zero and drops the gate; a
// rising clock level then advances the step, and a step that is not a rest
// loads its note as the glide target and retriggers the gate. The block takes
// one tick per clock cycle while results are read, and each result appears
// in the cycle after its tick is accepted. That rate is set by the pitch
// feedback loop, which holds a single 24 by 17 bit multiply and two adds
// between the pitch register and itself. The input side keeps taking ticks
// whenever the result register is empty or is being read in the same cycle.
// There is no start-up pass after reset. Configuration writes take effect at
// once and belong between ticks while no result is pending.
// ----------------------------------------------------------------------------
module step_sequencer_with_glide #(
    parameter int FRAC_BITS = sws_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_clock_level,
    input  logic                                  s_reset_level,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [sws_pkg::NOTE_W+FRAC_BITS-1:0]  m_note_pitch,
    output logic                                  m_gate_out,

    input  logic                                  cfg_wr_en,
    input  logic [sws_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [sws_pkg::CFG_DATA_W-1:0]        cfg_wr_data
);
    import sws_pkg::*;

    note_quad_t [NOTE_REGS-1:0] notes_reg;
    logic [MASK_W-1:0]          rest_reg;
    logic [LEN_W-1:0]           len_reg;
    logic [COEF_W-1:0]          coef_reg;

    logic                       m_valid_reg, m_valid_next;
    logic                       gate_reg;
    logic                       accept;
    sws_cfg_t                   cfg;
    sws_step_out_t              step_out;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            notes_reg[0] <= NOTES_RST_0;
            notes_reg[1] <= NOTES_RST_1;
            notes_reg[2] <= NOTES_RST_2;
            notes_reg[3] <= NOTES_RST_3;
            rest_reg     <= REST_RST;
            len_reg      <= LEN_RST;
            coef_reg     <= COEF_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_NOTES_0: notes_reg[0] <= cfg_wr_data;
                CFG_NOTES_1: notes_reg[1] <= cfg_wr_data;
                CFG_NOTES_2: notes_reg[2] <= cfg_wr_data;
                CFG_NOTES_3: notes_reg[3] <= cfg_wr_data;
                CFG_REST:    rest_reg     <= cfg_wr_data[MASK_W-1:0];
                CFG_LENGTH:  len_reg      <= cfg_wr_data[LEN_W-1:0];
                CFG_COEF:    coef_reg     <= cfg_wr_data[COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.notes      = notes_reg;
    assign cfg.rest_mask  = rest_reg;
    assign cfg.seq_length = len_reg;

    // A tick is taken whenever the result register is free or being read.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Gate result register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            gate_reg <= step_out.gate;
        end
    end

    sws_step_ctrl u_step_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .clock_level (s_clock_level),
        .reset_level (s_reset_level),
        .cfg         (cfg),
        .step_out    (step_out)
    );

    sws_glide #(
        .FRAC_BITS (FRAC_BITS)
    ) u_glide (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .coef        (coef_reg),
        .target_note (step_out.target_note),
        .pitch       (m_note_pitch)
    );

    assign m_valid    = m_valid_reg;
    assign m_gate_out = gate_reg;

`ifndef SYNTHESIS
    // Every accepted tick leaves a result waiting in the next cycle.
    a_accept_gives_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid
    ) else $error("accepted tick did not produce a result");

    // The pitch only moves when a tick is accepted.
    a_pitch_holds_idle: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(m_note_pitch)
    ) else $error("pitch changed without an accepted tick");

    // With glide off the pitch lands exactly on the target note.
    a_no_glide_jumps: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (accept && coef_reg == '0) |=>
            m_note_pitch == {$past(step_out.target_note), {FRAC_BITS{1'b0}}}
    ) else $error("pitch did not jump to target with glide off");
`endif

endmodule

// File: test/tb_step_sequencer_with_glide.sv
// ----------------------------------------------------------------------------
// tb_step_sequencer_with_glide
// Self-checking testbench for the CV/gate step sequencer with pitch glide.
// ----------------------------------------------------------------------------
// Ticks are sent as words on the input channel. Each accepted word is run
// through a local model of the sequencer (step counter, rests, gate counter
// and one-pole glide), and the expected pitch and gate are queued. Every
// result word is compared field by field with the oldest queued expectation.
// Directed tests cover the register extremes, both edge orders and the length
// corner cases; random traffic then runs under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_step_sequencer_with_glide;
    timeunit 1ns;
    timeprecision 1ps;

    import sws_pkg::*;

    localparam int PITCH_W = NOTE_W + FRAC_BITS_DEF;
    // Index that maps to no register; writes to it must be dropped.
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic [PITCH_W-1:0] note_pitch;
        logic               gate_out;
    } pitch_gate_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    logic s_clock_level = 1'b0;
    logic s_reset_level = 1'b0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [PITCH_W-1:0] m_note_pitch;
    logic               m_gate_out;

    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // Model copy of the registers.
    logic [CFG_DATA_W-1:0] note_bank [NOTE_REGS];
    logic [MASK_W-1:0]     rest_bits;
    logic [LEN_W-1:0]      length_reg;
    logic [COEF_W-1:0]     coef_reg;

    // Model copy of the sequencer state.
    logic [STEP_W-1:0]  seq_step;
    logic               prev_clock;
    logic               prev_reset;
    logic [GATE_W-1:0]  gate_left;
    logic [NOTE_W-1:0]  target;
    logic [PITCH_W-1:0] pitch;

    pitch_gate_t pending_pitch_gate[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    step_sequencer_with_glide dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_clock_level (s_clock_level),
        .s_reset_level (s_reset_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_note_pitch  (m_note_pitch),
        .m_gate_out    (m_gate_out),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Generous overall time limit.
    initial begin
        #4_000_000;
        $display("tb_step_sequencer_with_glide: errors");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
    endtask

    task automatic model_reset();
        note_bank[0] = NOTES_RST_0;
        note_bank[1] = NOTES_RST_1;
        note_bank[2] = NOTES_RST_2;
        note_bank[3] = NOTES_RST_3;
        rest_bits    = REST_RST;
        length_reg   = LEN_RST;
        coef_reg     = COEF_RST;
        seq_step     = '0;
        prev_clock   = 1'b0;
        prev_reset   = 1'b0;
        gate_left    = '0;
        target       = TARGET_RST;
        pitch        = PITCH_W'(TARGET_RST) << FRAC_BITS_DEF;
    endtask

    // Advance the model by one tick and return the pitch and gate it shows.
    task automatic next_pitch_and_gate(input logic clk_l, input logic rst_l,
                                       output pitch_gate_t res);
        int unsigned           span;
        logic [CFG_DATA_W-1:0] quad;
        logic [63:0]           tgt;
        logic [63:0]           acc;
        // Reset edge is handled before the clock edge.
        if (rst_l && !prev_reset) begin
            seq_step  = '0;
            gate_left = '0;
        end
        prev_reset = rst_l;
        if (clk_l && !prev_clock) begin
            span = length_reg;
            if (span < 1) span = 1;
            if (span > STEP_COUNT) span = STEP_COUNT;
            seq_step = STEP_W'((int'(seq_step) + 1) % span);
            // A rest step moves on but keeps the target and the gate count.
            if (!rest_bits[seq_step]) begin
                quad      = note_bank[seq_step[3:2]];
                target    = NOTE_W'(quad >> (7 * seq_step[1:0]));
                gate_left = GATE_W'(GATE_TICKS);
            end
        end
        prev_clock = clk_l;
        // One-pole glide with round half up; zero coefficient jumps.
        tgt = 64'(target) << FRAC_BITS_DEF;
        if (coef_reg == '0) begin
            pitch = PITCH_W'(tgt);
        end else begin
            acc = 64'(coef_reg) * 64'(pitch) + (64'd65536 - 64'(coef_reg)) * tgt
                  + 64'd32768;
            pitch = PITCH_W'(acc >> 16);
        end
        res.note_pitch = pitch;
        res.gate_out   = (gate_left != '0);
        if (gate_left != '0) gate_left = gate_left - 1'b1;
    endtask

    // Send one tick word, with an optional idle gap, and queue its result.
    task automatic send_tick(input logic clk_l, input logic rst_l);
        pitch_gate_t res;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_clock_level <= clk_l;
        s_reset_level <= rst_l;
        do @(posedge aclk); while (!s_ready);
        next_pitch_and_gate(clk_l, rst_l, res);
        pending_pitch_gate.push_back(res);
    endtask

    // Stop sending and wait until every queued result has come back.
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (pending_pitch_gate.size() != 0 && guard < 4000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (3) @(posedge aclk);
    endtask

    // Register write; only issued while no tick is in flight.
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (addr)
            CFG_NOTES_0, CFG_NOTES_1, CFG_NOTES_2, CFG_NOTES_3: begin
                note_bank[addr[1:0]] = data;
            end
            CFG_REST: begin
                rest_bits = data[MASK_W-1:0];
            end
            CFG_LENGTH: begin
                length_reg = data[LEN_W-1:0];
            end
            CFG_COEF: begin
                coef_reg = data[COEF_W-1:0];
            end
            default: begin
            end
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Result checker: each result word against the oldest expectation.
    always @(posedge aclk) begin : result_check
        pitch_gate_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pitch_gate.size() == 0) begin
                report_mismatch("result word with no tick waiting");
            end else begin
                exp_res = pending_pitch_gate.pop_front();
                if (m_note_pitch !== exp_res.note_pitch) begin
                    report_mismatch($sformatf("note_pitch got %h expected %h",
                                              m_note_pitch, exp_res.note_pitch));
                end
                if (m_gate_out !== exp_res.gate_out) begin
                    report_mismatch($sformatf("gate_out got %b expected %b",
                                              m_gate_out, exp_res.gate_out));
                end
            end
        end
    end

    // Default registers: a few clock edges through the reset sequence.
    task automatic test_default_steps();
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
    endtask

    // Reset alone, reset held high, and reset together with a clock edge.
    task automatic test_reset_edges();
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        wait_drained();
    endtask

    // Note extremes, a rest step, oversize length, then shrink and zero length.
    task automatic test_length_and_rests();
        cfg_write(CFG_NOTES_0, '0);
        cfg_write(CFG_NOTES_1, '1);
        cfg_write(CFG_NOTES_2, CFG_DATA_W'($urandom));
        cfg_write(CFG_NOTES_3, CFG_DATA_W'($urandom));
        cfg_write(CFG_REST, {12'hFFF, 16'h0004});
        cfg_write(CFG_LENGTH, {23'h7FFFFF, 5'd31});
        cfg_write(CFG_COEF, '0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        wait_drained();
        // Step is now beyond the new length; the next edge wraps modulo it.
        cfg_write(CFG_LENGTH, 28'd3);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        wait_drained();
        cfg_write(CFG_LENGTH, 28'd0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        wait_drained();
    endtask

    // Glide at the largest and smallest nonzero coefficients; a write to a spare index.
    task automatic test_glide_extremes();
        cfg_write(CFG_NOTES_0, '1);
        cfg_write(CFG_COEF, {12'hABC, 16'hFFFF});
        cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        wait_drained();
        cfg_write(CFG_COEF, 28'd1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        wait_drained();
    endtask

    // Random register setting; the index steers length and coefficient extremes.
    task automatic program_setting(input int idx);
        logic [MASK_W-1:0] mask;
        logic [LEN_W-1:0]  len;
        logic [COEF_W-1:0] coef;
        for (int r = 0; r < NOTE_REGS; r++) begin
            cfg_write(CFG_ADDR_W'(int'(CFG_NOTES_0) + r), CFG_DATA_W'($urandom));
        end
        case ($urandom_range(3))
            0: mask = '0;
            1: mask = '1;
            2: mask = MASK_W'($urandom & $urandom);
            default: mask = MASK_W'($urandom);
        endcase
        cfg_write(CFG_REST, {12'($urandom), mask});
        case (idx)
            0: len = 5'd16;
            1: len = 5'd1;
            2: len = 5'd0;
            3: len = 5'd31;
            default: len = LEN_W'($urandom_range(31));
        endcase
        cfg_write(CFG_LENGTH, {23'($urandom), len});
        case (idx)
            0: coef = '0;
            1: coef = '1;
            2: coef = 16'd1;
            default: coef = ($urandom_range(3) == 0) ? '0 : COEF_W'($urandom);
        endcase
        cfg_write(CFG_COEF, {12'($urandom), coef});
    endtask

    // Mostly clean clock bursts, some reset pulses, some noise.
    task automatic emit_random_ticks(input int count);
        int   sent;
        int   pick;
        int   edges;
        int   hi_len;
        int   lo_len;
        logic rst_l;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                edges  = $urandom_range(6, 1);
                hi_len = $urandom_range(3, 1);
                lo_len = $urandom_range(3, 1);
                rst_l  = ($urandom_range(9) == 0);
                repeat (edges) begin
                    repeat (hi_len) begin
                        send_tick(1'b1, rst_l);
                        sent++;
                    end
                    repeat (lo_len) begin
                        send_tick(1'b0, rst_l);
                        sent++;
                    end
                end
            end else if (pick < 88) begin
                repeat ($urandom_range(2, 1)) begin
                    send_tick(1'($urandom), 1'b1);
                    sent++;
                end
            end else begin
                repeat ($urandom_range(8, 1)) begin
                    send_tick(1'($urandom), 1'($urandom));
                    sent++;
                end
            end
        end
    endtask

    // Random traffic under each idle and stall mix, two settings per mix.
    task automatic test_random_traffic();
        int send_pcts [4] = '{0, 71, 0, 33};
        int recv_pcts [4] = '{0, 0, 71, 33};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            for (int s = 0; s < 2; s++) begin
                wait_drained();
                program_setting(p * 2 + s);
                emit_random_ticks(50);
            end
        end
        wait_drained();
    endtask

    // Trigger the gate, then make every step a rest until the gate runs out.
    task automatic test_gate_timeout();
        cfg_write(CFG_REST, '0);
        cfg_write(CFG_LENGTH, 28'd16);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        wait_drained();
        cfg_write(CFG_REST, '1);
        repeat (GATE_TICKS + 80) begin
            send_tick(1'($urandom), 1'b0);
        end
        wait_drained();
    endtask

    initial begin
        model_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_steps();
        test_reset_edges();
        test_length_and_rests();
        test_glide_extremes();
        test_random_traffic();
        test_gate_timeout();

        wait_drained();
        if (pending_pitch_gate.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_pitch_gate.size()));
        end
        if (error_count == 0) begin
            $display("tb_step_sequencer_with_glide: clean");
        end else begin
            $display("tb_step_sequencer_with_glide: errors");
        end
        $finish;
    end

endmodule

// File: step_sequencer_with_glide.f
rtl/core/sws_pkg.sv
rtl/core/sws_step_ctrl.sv
rtl/core/sws_glide.sv
rtl/core/step_sequencer_with_glide.sv
test/tb_step_sequencer_with_glide.sv
